FILE: rtl/bpr_pkg.sv
// shared types and constants for the byte pattern replace unit
// used by the window cell, the burst cell and the top level; depends on nothing
package bpr_pkg;

    localparam int BYTE_W   = 8;
    localparam int REPL_MAX = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPL_BYTES     = 2'd2,
        CFG_REPL_LENGTH    = 2'd3
    } cfg_index_t;

    // one result entry as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              present;
        logic              last;
    } res_t;

    // broadcast control for the window cells
    typedef struct packed {
        logic write_en;
        logic shift;
    } win_ctrl_t;

    // per slot control for the output burst cells
    typedef struct packed {
        logic load;
        logic drain;
    } burst_ctrl_t;

endpackage

FILE: rtl/bpr_window_cell.sv
// one byte of the match window: holds a byte, merges the incoming byte
// when it is the insert slot, compares against its pattern byte; uses bpr_pkg
module bpr_window_cell
(
    input  logic                             clk,
    input  bpr_pkg::win_ctrl_t               ctrl,
    input  logic                             slot,
    input  logic [bpr_pkg::BYTE_W-1:0]       in_byte,
    input  logic [bpr_pkg::BYTE_W-1:0]       pat_byte,
    input  logic [bpr_pkg::BYTE_W-1:0]       nbr_cand,
    output logic [bpr_pkg::BYTE_W-1:0]       cand,
    output logic                             eq
);

    logic [bpr_pkg::BYTE_W-1:0] data_reg;
    logic [bpr_pkg::BYTE_W-1:0] data_next;

    // window content as it stands once the incoming byte is in place
    assign cand = slot ? in_byte : data_reg;
    assign eq   = (cand == pat_byte);

    // on a full window without a match everything moves one place toward the oldest end
    assign data_next = ctrl.shift ? nbr_cand : cand;

    always_ff @(posedge clk)
    begin
        if (ctrl.write_en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/bpr_burst_cell.sv
// one slot of the output burst chain: shifts toward the output port on
// every transfer and takes a fresh result when loaded; uses bpr_pkg
module bpr_burst_cell
(
    input  logic                 clk,
    input  bpr_pkg::burst_ctrl_t ctrl,
    input  bpr_pkg::res_t        load_val,
    input  bpr_pkg::res_t        nbr_val,
    output bpr_pkg::res_t        q
);

    bpr_pkg::res_t entry_reg;
    bpr_pkg::res_t entry_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            entry_next = load_val;
        end
        else if (ctrl.drain)
        begin
            entry_next = nbr_val;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

FILE: rtl/byte_pattern_replace_unit.sv
// top level of the streaming find-and-replace unit: config registers, window
// cell chain, result list and output burst chain; uses bpr_pkg, bpr_window_cell, bpr_burst_cell
//
//  port group  | role   | payload
//  ------------+--------+--------------------------------------------------------
//  s_axis_*    | input  | tdata[7:0] data_byte, tuser byte_present, tlast end_of_string
//  m_axis_*    | output | tdata[7:0] out_byte, tuser out_present, tlast out_last
//  cfg_*       | write  | cfg_index register, cfg_data value (always ready)
//
// an input transfer is taken every cycle while the burst chain holds at most one
// result; each item loads 0 to max(MAX_PATTERN, 8) results into the burst chain,
// which sends one result per cycle while m_axis_tready is high
// a match emits the replacement in one burst; an end item flushes the window
// reset clears the window fill, the burst count and the config registers, but sets pattern length to 1
// input ready comes from the burst count register only, never from m_axis_tready
module byte_pattern_replace_unit
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tuser,   // [0] byte_present
    input  logic                            s_axis_tlast,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
    output logic                            m_axis_tuser,   // [0] out_present
    output logic                            m_axis_tlast,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data
);

    localparam int NLIST  = (MAX_PATTERN > bpr_pkg::REPL_MAX) ? MAX_PATTERN : bpr_pkg::REPL_MAX;
    localparam int DEPTH  = NLIST + 1;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LCNT_W = $clog2(NLIST + 1);
    localparam int BW     = bpr_pkg::BYTE_W;

    function automatic logic [FILL_W-1:0] clamp_plen(input logic [3:0] v);
        logic [FILL_W-1:0] r;
        if (v == 4'd0)
        begin
            r = FILL_W'(1);
        end
        else if (int'(v) > MAX_PATTERN)
        begin
            r = FILL_W'(MAX_PATTERN);
        end
        else
        begin
            r = FILL_W'(v);
        end
        return r;
    endfunction

    // config registers
    logic [63:0]        pat_bytes_reg;
    logic [3:0]         pat_len_reg;
    logic [63:0]        repl_bytes_reg;
    logic [3:0]         repl_len_reg;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               accept;
    logic               cfg_write;
    logic               pres;
    logic               eos;
    logic [FILL_W-1:0]  plen;
    logic [FILL_W-1:0]  fill_base;
    logic [FILL_W-1:0]  fcur;
    logic               full;
    logic               match;
    logic [3:0]         rlen;
    logic [LCNT_W-1:0]  cnt;
    logic               bare;
    logic               drain;
    logic               base;

    logic [BW-1:0]          cand [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] eq_masked;
    bpr_pkg::win_ctrl_t     win_ctrl;

    bpr_pkg::res_t          item  [NLIST];
    bpr_pkg::res_t          slot_q [DEPTH];
    bpr_pkg::burst_ctrl_t   bctrl [DEPTH];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign pres      = s_axis_tuser;
    assign eos       = s_axis_tlast;

    assign plen      = clamp_plen(pat_len_reg);
    assign fill_base = (fill_reg >= plen) ? '0 : fill_reg;
    assign fcur      = pres ? (fill_base + FILL_W'(1)) : fill_reg;
    assign full      = pres && ((fill_base + FILL_W'(1)) == plen);
    assign rlen      = (repl_len_reg > 4'(bpr_pkg::REPL_MAX)) ? 4'(bpr_pkg::REPL_MAX)
                                                              : repl_len_reg;

    // window cell chain
    assign win_ctrl.write_en = accept && pres;
    assign win_ctrl.shift    = full && !match;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_win
            logic [BW-1:0] pat_b;
            logic [BW-1:0] nbr_b;
            logic          slot_b;

            if (gi < 8)
            begin : g_pat
                assign pat_b = pat_bytes_reg[BW*gi +: BW];
            end
            else
            begin : g_pat_zero
                assign pat_b = '0;
            end

            if (gi < MAX_PATTERN - 1)
            begin : g_nbr
                assign nbr_b = cand[gi+1];
            end
            else
            begin : g_nbr_end
                assign nbr_b = '0;
            end

            assign slot_b       = pres && (fill_base == FILL_W'(gi));
            assign eq_masked[gi] = eq[gi] || (FILL_W'(gi) >= plen);

            bpr_window_cell u_cell
            (
                .clk      (clk),
                .ctrl     (win_ctrl),
                .slot     (slot_b),
                .in_byte  (s_axis_tdata),
                .pat_byte (pat_b),
                .nbr_cand (nbr_b),
                .cand     (cand[gi]),
                .eq       (eq[gi])
            );
        end
    endgenerate

    assign match = full && (&eq_masked);

    // number of results this item produces
    always_comb
    begin
        if (match)
        begin
            cnt = LCNT_W'(rlen);
        end
        else if (eos)
        begin
            cnt = LCNT_W'(fcur);
        end
        else
        begin
            cnt = full ? LCNT_W'(1) : '0;
        end
        bare = 1'b0;
        if (eos && (cnt == '0))
        begin
            cnt  = LCNT_W'(1);
            bare = 1'b1;
        end
    end

    // result list: replacement bytes on a match, window bytes otherwise, an empty entry on a bare end item
    generate
        for (gi = 0; gi < NLIST; gi++)
        begin : g_item
            logic [BW-1:0] repl_b;
            logic [BW-1:0] win_b;

            if (gi < bpr_pkg::REPL_MAX)
            begin : g_repl
                assign repl_b = repl_bytes_reg[BW*gi +: BW];
            end
            else
            begin : g_repl_zero
                assign repl_b = '0;
            end

            if (gi < MAX_PATTERN)
            begin : g_wb
                assign win_b = cand[gi];
            end
            else
            begin : g_wb_zero
                assign win_b = '0;
            end

            always_comb
            begin
                item[gi].value   = bare ? '0 : (match ? repl_b : win_b);
                item[gi].present = !bare;
                item[gi].last    = eos && (LCNT_W'(gi) == (cnt - LCNT_W'(1)));
            end
        end
    endgenerate

    // output burst chain; a pending result may sit in slot 0 while a new item
    // loads behind it, so the load lands at offset 0 or 1
    assign m_axis_tvalid = (count_reg != '0);
    assign drain         = m_axis_tvalid && m_axis_tready;
    assign base          = (count_reg == CNT_W'(1)) && !drain;
    assign s_axis_tready = (count_reg <= CNT_W'(1));

    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_burst
            bpr_pkg::res_t ld_b;
            bpr_pkg::res_t nbr_b;
            logic          in0;
            logic          in1;

            if (gi < NLIST)
            begin : g_l0
                assign in0 = (gi < int'(cnt));
            end
            else
            begin : g_l0_none
                assign in0 = 1'b0;
            end

            if (gi >= 1)
            begin : g_l1
                assign in1 = ((gi - 1) < int'(cnt));
            end
            else
            begin : g_l1_none
                assign in1 = 1'b0;
            end

            if (gi >= 1 && gi < NLIST)
            begin : g_ld_both
                assign ld_b = base ? item[gi-1] : item[gi];
            end
            else if (gi >= 1)
            begin : g_ld_hi
                assign ld_b = item[gi-1];
            end
            else
            begin : g_ld_lo
                assign ld_b = item[gi];
            end

            if (gi < DEPTH - 1)
            begin : g_bn
                assign nbr_b = slot_q[gi+1];
            end
            else
            begin : g_bn_end
                assign nbr_b = '0;
            end

            assign bctrl[gi].load  = accept && (base ? in1 : in0);
            assign bctrl[gi].drain = drain;

            bpr_burst_cell u_bcell
            (
                .clk      (clk),
                .ctrl     (bctrl[gi]),
                .load_val (ld_b),
                .nbr_val  (nbr_b),
                .q        (slot_q[gi])
            );
        end
    endgenerate

    assign m_axis_tdata = slot_q[0].value;
    assign m_axis_tuser = slot_q[0].present;
    assign m_axis_tlast = slot_q[0].last;

    always_comb
    begin
        count_next = count_reg - CNT_W'(drain);
        if (accept)
        begin
            count_next = count_next + CNT_W'(cnt);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (eos || match)
            begin
                fill_next = '0;
            end
            else if (full)
            begin
                fill_next = plen - FILL_W'(1);
            end
            else
            begin
                fill_next = fcur;
            end
        end
        else if (cfg_write && (cfg_index == bpr_pkg::CFG_PATTERN_LENGTH))
        begin
            // a pattern length at or below the held fill drops the held bytes
            if (clamp_plen(cfg_data[3:0]) <= fill_reg)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg  <= '0;
            pat_len_reg    <= 4'd1;
            repl_bytes_reg <= '0;
            repl_len_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bpr_pkg::CFG_PATTERN_BYTES:  pat_bytes_reg  <= cfg_data;
                bpr_pkg::CFG_PATTERN_LENGTH: pat_len_reg    <= cfg_data[3:0];
                bpr_pkg::CFG_REPL_BYTES:     repl_bytes_reg <= cfg_data;
                bpr_pkg::CFG_REPL_LENGTH:    repl_len_reg   <= cfg_data[3:0];
                default:                     ;
            endcase
        end
    end

    // window never holds a full pattern between items
    a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < plen)
        else $error("window fill reached pattern length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("burst chain overflow");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> count_reg != '0)
        else $error("end of string produced no result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> fill_reg == '0)
        else $error("window not flushed at end of string");

endmodule
